[hw/rtl/owsp_pkg.sv]
// ----------------------------------------------------------------------------
// owsp_pkg
// Shared constants, register codes and helpers of the omni wheel speed to PWM
// block.
// ----------------------------------------------------------------------------
package owsp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_WHEELS    = 4;

    // wheel magnitude before and after speed limiting
    localparam int MAG_W = 34;
    localparam int SPD_W = 31;
    localparam int PWM_W = 16;
    localparam int CFG_W = 31;
    localparam int IDX_W = 3;

    localparam logic [63:0] SQRT_HALF_Q32 = 64'd3037000500;

    localparam logic [IDX_W-1:0] REG_INV_RADIUS = 3'd0;
    localparam logic [IDX_W-1:0] REG_BODY_RAD   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_SPEED  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEAD_BAND  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PWM_PERIOD = 3'd5;

    localparam logic [23:0]      RST_INV_RADIUS = 24'd3276800;
    localparam logic [15:0]      RST_BODY_RAD   = 16'd5997;
    localparam logic [SPD_W-1:0] RST_MAX_SPEED  = 31'd1921616;
    localparam logic [SPD_W-1:0] RST_MIN_SPEED  = 31'd1152970;
    localparam logic [SPD_W-1:0] RST_DEAD_BAND  = 31'd131072;
    localparam logic [PWM_W-1:0] RST_PWM_PERIOD = 16'd1000;

    // round(sqrt(1/2) * 2^frac)
    function automatic logic [63:0] owsp_sqrt_half(input int frac);
        return (SQRT_HALF_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

endpackage

[hw/rtl/owsp_div.sv]
// ----------------------------------------------------------------------------
// owsp_div
// Pipelined restoring divider, one quotient bit per stage, with side band
// carried alongside and an overflow flag for quotients beyond QW bits.
// ----------------------------------------------------------------------------
module owsp_div #(
    parameter int NW = 65,
    parameter int DW = 34,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic          ovf,
    output logic [SW-1:0] side_out
);

    localparam int HW = NW - QW;
    localparam int RW = (HW > DW) ? HW : DW;

    logic [RW-1:0] hi_ext;

    logic          v_reg    [QW+1];
    logic [DW-1:0] r_reg    [QW+1];
    logic [QW-1:0] nl_reg   [QW+1];
    logic [DW-1:0] d_reg    [QW+1];
    logic          ovf_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];

    logic [DW-1:0] r_next   [QW];
    logic [QW-1:0] nl_next  [QW];

    assign hi_ext = RW'(num[NW-1:QW]);

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] t;
        logic [DW:0] diff;
        logic        ge;
        assign t          = {r_reg[k], nl_reg[k][QW-1]};
        assign diff       = t - {1'b0, d_reg[k]};
        assign ge         = t >= {1'b0, d_reg[k]};
        assign r_next[k]  = ge ? diff[DW-1:0] : t[DW-1:0];
        assign nl_next[k] = {nl_reg[k][QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= hi_ext[DW-1:0];
        nl_reg[0]   <= num[QW-1:0];
        d_reg[0]    <= den;
        ovf_reg[0]  <= hi_ext >= RW'(den);
        side_reg[0] <= side_in;
        for (int k = 0; k < QW; k++)
        begin
            r_reg[k+1]    <= r_next[k];
            nl_reg[k+1]   <= nl_next[k];
            d_reg[k+1]    <= d_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[QW];
    assign quot      = nl_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

    a_rem_out: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QW] && !ovf_reg[QW] |-> r_reg[QW] < d_reg[QW])
        else $error("remainder not below divisor at output");

    a_rem_in: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !ovf_reg[0] |-> r_reg[0] < d_reg[0])
        else $error("initial remainder not below divisor");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && d_reg[0] == '0 |-> ovf_reg[0])
        else $error("zero divisor without overflow");

endmodule

[hw/rtl/omni_wheel_speed_to_pwm.sv]
// ----------------------------------------------------------------------------
// omni_wheel_speed_to_pwm
// Four-wheel omni inverse kinematics: body velocity command to wheel speeds,
// speed limiting and boost, then forward / reverse PWM compare values.
// ----------------------------------------------------------------------------
// channel   | handshake         | payload
// command   | start, busy       | vel_x, vel_y, vel_turn
// result    | done (one cycle)  | wheel1..4_fwd, wheel1..4_rev
// config    | cfg_we            | cfg_index, cfg_data
//
// One command enters every cycle; busy stays low.
// done rises once per command, in command order.
// The path holds three restoring dividers of 32, 32 and 17 register stages.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall; nothing is held back.
// ----------------------------------------------------------------------------
module omni_wheel_speed_to_pwm
    import owsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      vel_x,
    input  logic signed [15:0]      vel_y,
    input  logic signed [15:0]      vel_turn,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output logic                    done,
    output logic [PWM_W-1:0]        wheel1_fwd,
    output logic [PWM_W-1:0]        wheel1_rev,
    output logic [PWM_W-1:0]        wheel2_fwd,
    output logic [PWM_W-1:0]        wheel2_rev,
    output logic [PWM_W-1:0]        wheel3_fwd,
    output logic [PWM_W-1:0]        wheel3_rev,
    output logic [PWM_W-1:0]        wheel4_fwd,
    output logic [PWM_W-1:0]        wheel4_rev
);

    localparam logic [FRAC_BITS-1:0] SQ = FRAC_BITS'(owsp_sqrt_half(FRAC_BITS));
    localparam int PW = FRAC_BITS + 19;
    localparam int FW = FRAC_BITS + 36;
    localparam int N  = NUM_WHEELS;

    logic [23:0]      inv_radius_reg;
    logic [15:0]      body_rad_reg;
    logic [SPD_W-1:0] max_speed_reg;
    logic [SPD_W-1:0] min_speed_reg;
    logic [SPD_W-1:0] dead_band_reg;
    logic [PWM_W-1:0] pwm_period_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, done_reg;

    logic signed [17:0]   lin_next  [N];
    logic signed [17:0]   lin_reg   [N];
    logic signed [32:0]   rot_next;
    logic signed [32:0]   rot_reg;
    logic signed [32:0]   rot2_reg;
    logic signed [PW-1:0] prod_reg  [N];
    logic [MAG_W-1:0]     m_reg     [N];
    logic                 neg3_reg  [N];
    logic [MAG_W-1:0]     mag4_reg  [N];
    logic                 neg4_reg  [N];
    logic [MAG_W-1:0]     mag5_reg  [N];
    logic                 neg5_reg  [N];
    logic [MAG_W-1:0]     largest_next;
    logic [MAG_W-1:0]     largest_reg;
    logic [MAG_W-1:0]     largest6_reg;
    logic                 scale6_reg;
    logic [64:0]          nsd_reg   [N];
    logic [MAG_W-1:0]     mag6_reg  [N];
    logic                 neg6_reg  [N];

    logic                 d1v       [N];
    logic [SPD_W-1:0]     q1        [N];
    logic                 ovf1      [N];
    logic [MAG_W+1:0]     side1     [N];

    logic [SPD_W-1:0]     mag7_reg  [N];
    logic                 neg7_reg  [N];
    logic [SPD_W-1:0]     mag8_reg  [N];
    logic                 neg8_reg  [N];
    logic                 above8_reg[N];
    logic [31:0]          cand      [N];
    logic [31:0]          min_a, min_b, min_ab;
    logic [SPD_W-1:0]     mag9_reg  [N];
    logic                 neg9_reg  [N];
    logic                 above9_reg[N];
    logic [SPD_W-1:0]     small9_reg;
    logic                 boost9_reg;
    logic [61:0]          nb_reg    [N];
    logic [SPD_W-1:0]     mag10_reg [N];
    logic                 neg10_reg [N];
    logic                 apply10_reg[N];
    logic [SPD_W-1:0]     small10_reg;

    logic                 d2v       [N];
    logic [SPD_W-1:0]     q2        [N];
    logic                 ovf2      [N];
    logic [SPD_W+1:0]     side2     [N];

    logic [SPD_W-1:0]     magb11_reg[N];
    logic                 neg11_reg [N];
    logic [46:0]          np_reg    [N];
    logic                 neg12_reg [N];
    logic                 nz12_reg  [N];

    logic                 d3v       [N];
    logic [PWM_W-1:0]     q3        [N];
    logic                 ovf3      [N];
    logic [1:0]           side3     [N];

    logic [PWM_W-1:0]     fwd_reg   [N];
    logic [PWM_W-1:0]     rev_reg   [N];

    assign busy = 1'b0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_radius_reg <= RST_INV_RADIUS;
            body_rad_reg   <= RST_BODY_RAD;
            max_speed_reg  <= RST_MAX_SPEED;
            min_speed_reg  <= RST_MIN_SPEED;
            dead_band_reg  <= RST_DEAD_BAND;
            pwm_period_reg <= RST_PWM_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_RADIUS: inv_radius_reg <= cfg_data[23:0];
                REG_BODY_RAD:   body_rad_reg   <= cfg_data[15:0];
                REG_MAX_SPEED:  max_speed_reg  <= cfg_data[SPD_W-1:0];
                REG_MIN_SPEED:  min_speed_reg  <= cfg_data[SPD_W-1:0];
                REG_DEAD_BAND:  dead_band_reg  <= cfg_data[SPD_W-1:0];
                REG_PWM_PERIOD: pwm_period_reg <= cfg_data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    // valid chain outside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            v11_reg  <= 1'b0;
            v12_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= d1v[0] & d1v[1] & d1v[2] & d1v[3];
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            v11_reg  <= d2v[0] & d2v[1] & d2v[2] & d2v[3];
            v12_reg  <= v11_reg;
            done_reg <= d3v[0] & d3v[1] & d3v[2] & d3v[3];
        end
    end

    // body terms
    always_comb
    begin
        lin_next[0] = -18'(vel_x) + 18'(vel_y);
        lin_next[1] = -18'(vel_x) - 18'(vel_y);
        lin_next[2] =  18'(vel_x) - 18'(vel_y);
        lin_next[3] =  18'(vel_x) + 18'(vel_y);
        rot_next    = $signed({1'b0, body_rad_reg}) * vel_turn;
    end

    // largest wheel and smallest running wheel
    always_comb
    begin
        largest_next = (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        if (mag4_reg[2] > largest_next)
        begin
            largest_next = mag4_reg[2];
        end
        if (mag4_reg[3] > largest_next)
        begin
            largest_next = mag4_reg[3];
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cand[i] = above8_reg[i] ? {1'b0, mag8_reg[i]} : '1;
        end
        min_a  = (cand[0] < cand[1]) ? cand[0] : cand[1];
        min_b  = (cand[2] < cand[3]) ? cand[2] : cand[3];
        min_ab = (min_a < min_b) ? min_a : min_b;
    end

    always_ff @(posedge clk)
    begin
        rot_reg      <= rot_next;
        rot2_reg     <= rot_reg;
        largest_reg  <= largest_next;
        largest6_reg <= largest_reg;
        scale6_reg   <= largest_reg > MAG_W'(max_speed_reg);
        small9_reg   <= min_ab[SPD_W-1:0];
        boost9_reg   <= (above8_reg[0] | above8_reg[1] | above8_reg[2] | above8_reg[3])
                        && (min_ab < {1'b0, min_speed_reg});
        small10_reg  <= small9_reg;
    end

    for (genvar g = 0; g < N; g++) begin : g_lane
        logic signed [FW-1:0] full;
        logic [FW-1:0]        absv;
        logic [57:0]          mprod;
        logic [SPD_W-1:0]     pwm;

        assign full  = (FW'(prod_reg[g]) <<< 16) + (FW'(rot2_reg) <<< FRAC_BITS);
        assign absv  = full[FW-1] ? FW'(-full) : FW'(full);
        assign mprod = m_reg[g] * inv_radius_reg;
        assign pwm   = ovf3[g] ? '0 : SPD_W'(q3[g]);

        always_ff @(posedge clk)
        begin
            lin_reg[g]     <= lin_next[g];
            prod_reg[g]    <= $signed({1'b0, SQ}) * lin_reg[g];
            m_reg[g]       <= absv[FRAC_BITS+MAG_W-1:FRAC_BITS];
            neg3_reg[g]    <= full[FW-1];
            mag4_reg[g]    <= mprod[57:24];
            neg4_reg[g]    <= neg3_reg[g];
            mag5_reg[g]    <= mag4_reg[g];
            neg5_reg[g]    <= neg4_reg[g];
            nsd_reg[g]     <= mag5_reg[g] * max_speed_reg;
            mag6_reg[g]    <= mag5_reg[g];
            neg6_reg[g]    <= neg5_reg[g];

            mag7_reg[g]    <= (side1[g][MAG_W] && !ovf1[g]) ? q1[g] : side1[g][SPD_W-1:0];
            neg7_reg[g]    <= side1[g][MAG_W+1];
            mag8_reg[g]    <= mag7_reg[g];
            neg8_reg[g]    <= neg7_reg[g];
            above8_reg[g]  <= mag7_reg[g] > dead_band_reg;
            mag9_reg[g]    <= mag8_reg[g];
            neg9_reg[g]    <= neg8_reg[g];
            above9_reg[g]  <= above8_reg[g];
            nb_reg[g]      <= mag9_reg[g] * min_speed_reg;
            mag10_reg[g]   <= mag9_reg[g];
            neg10_reg[g]   <= neg9_reg[g];
            apply10_reg[g] <= boost9_reg && above9_reg[g];

            if (side2[g][SPD_W])
            begin
                magb11_reg[g] <= (ovf2[g] || q2[g] > max_speed_reg) ? max_speed_reg : q2[g];
            end
            else
            begin
                magb11_reg[g] <= side2[g][SPD_W-1:0];
            end
            neg11_reg[g]   <= side2[g][SPD_W+1];
            np_reg[g]      <= magb11_reg[g] * pwm_period_reg;
            neg12_reg[g]   <= neg11_reg[g];
            nz12_reg[g]    <= magb11_reg[g] != '0;

            fwd_reg[g]     <= (side3[g][0] && !side3[g][1]) ? pwm[PWM_W-1:0] : '0;
            rev_reg[g]     <= (side3[g][0] &&  side3[g][1]) ? pwm[PWM_W-1:0] : '0;
        end

        owsp_div #(.NW(65), .DW(MAG_W), .QW(SPD_W), .SW(MAG_W + 2)) u_div_scale (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v6_reg),
            .num       (nsd_reg[g]),
            .den       (largest6_reg),
            .side_in   ({neg6_reg[g], scale6_reg, mag6_reg[g]}),
            .out_valid (d1v[g]),
            .quot      (q1[g]),
            .ovf       (ovf1[g]),
            .side_out  (side1[g])
        );

        owsp_div #(.NW(62), .DW(SPD_W), .QW(SPD_W), .SW(SPD_W + 2)) u_div_boost (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v10_reg),
            .num       (nb_reg[g]),
            .den       (small10_reg),
            .side_in   ({neg10_reg[g], apply10_reg[g], mag10_reg[g]}),
            .out_valid (d2v[g]),
            .quot      (q2[g]),
            .ovf       (ovf2[g]),
            .side_out  (side2[g])
        );

        owsp_div #(.NW(47), .DW(SPD_W), .QW(PWM_W), .SW(2)) u_div_pwm (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v12_reg),
            .num       (np_reg[g]),
            .den       (max_speed_reg),
            .side_in   ({neg12_reg[g], nz12_reg[g]}),
            .out_valid (d3v[g]),
            .quot      (q3[g]),
            .ovf       (ovf3[g]),
            .side_out  (side3[g])
        );
    end

    assign done       = done_reg;
    assign wheel1_fwd = fwd_reg[0];
    assign wheel1_rev = rev_reg[0];
    assign wheel2_fwd = fwd_reg[1];
    assign wheel2_rev = rev_reg[1];
    assign wheel3_fwd = fwd_reg[2];
    assign wheel3_rev = rev_reg[2];
    assign wheel4_fwd = fwd_reg[3];
    assign wheel4_rev = rev_reg[3];

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel1_fwd == '0 || wheel1_rev == '0) && (wheel2_fwd == '0 || wheel2_rev == '0)
              && (wheel3_fwd == '0 || wheel3_rev == '0) && (wheel4_fwd == '0 || wheel4_rev == '0))
        else $error("both half-bridges driven on one wheel");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel1_fwd | wheel1_rev) <= pwm_period_reg
              && (wheel2_fwd | wheel2_rev) <= pwm_period_reg
              && (wheel3_fwd | wheel3_rev) <= pwm_period_reg
              && (wheel4_fwd | wheel4_rev) <= pwm_period_reg)
        else $error("compare value beyond full duty");

    a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg |-> mag7_reg[0] <= max_speed_reg && mag7_reg[1] <= max_speed_reg
                && mag7_reg[2] <= max_speed_reg && mag7_reg[3] <= max_speed_reg)
        else $error("wheel speed above limit after scale down");

    a_boost_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v11_reg |-> magb11_reg[0] <= max_speed_reg && magb11_reg[1] <= max_speed_reg
                 && magb11_reg[2] <= max_speed_reg && magb11_reg[3] <= max_speed_reg)
        else $error("wheel speed above limit after boost");

endmodule
